// ----- src/firmware_table_structure_locator_unit_macros.svh -----
// assertion helpers for the checker file
`ifndef FIRMWARE_TABLE_STRUCTURE_LOCATOR_UNIT_MACROS_SVH
`define FIRMWARE_TABLE_STRUCTURE_LOCATOR_UNIT_MACROS_SVH

// same-cycle implication, quiet while reset is high
`define FTSL_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("ftsl check failed");

// next-cycle implication, quiet while reset is high
`define FTSL_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("ftsl check failed");

// next-cycle implication that also holds across reset
`define FTSL_ASSERT_ALWAYS_NEXT(label, clk, ante, cons) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("ftsl check failed");

`endif

// ----- src/ftsl_pkg.sv -----
`default_nettype none
package ftsl_pkg;

  localparam logic [7:0] END_TYPE   = 8'd127;
  localparam logic [7:0] MIN_HEADER = 8'd4;
  localparam logic [7:0] SEEN_MAX   = 8'd255;

  localparam int CFG_INDEX_W = 2;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_TYPE  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_TARGET_INDEX = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_TABLE_LENGTH = 2'd2;
  localparam int CFG_DATA_W = 16;

  localparam int STATUS_W = 3;

  typedef enum logic [STATUS_W-1:0] {
    ST_FOUND     = 3'd0,
    ST_END_TYPE  = 3'd1,
    ST_BAD_LEN   = 3'd2,
    ST_UNTERM    = 3'd3,
    ST_OVER      = 3'd4,
    ST_STREAM    = 3'd5
  } status_t;

  typedef enum logic [2:0] {
    PH_TYPE   = 3'b001,
    PH_LENGTH = 3'b010,
    PH_BODY   = 3'b100
  } phase_t;

  typedef struct packed {
    logic [7:0]  target_type;
    logic [7:0]  target_index;
    logic [15:0] table_length;
  } cfg_t;

  // one classified table byte as it travels through the queue
  typedef struct packed {
    logic [7:0] data_byte;
    logic       first_byte;
    logic       last_byte;
    logic       is_zero;
    logic       is_target;
    logic       is_end_type;
    logic       short_len;
  } item_t;

endpackage
`default_nettype wire

// ----- src/ftsl_front.sv -----
`default_nettype none
module ftsl_front (
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]      s_tuser,   // [0] first_byte
  input  wire logic            s_tlast,   // last_byte
  input  wire ftsl_pkg::cfg_t  cfg,
  input  wire logic            q_full,
  output logic                 q_write,
  output ftsl_pkg::item_t      q_item
);

  assign s_tready = !q_full;
  assign q_write  = s_tvalid && !q_full;

  always_comb begin
    q_item.data_byte   = s_tdata;
    q_item.first_byte  = s_tuser[0];
    q_item.last_byte   = s_tlast;
    q_item.is_zero     = (s_tdata == 8'd0);
    q_item.is_target   = (s_tdata == cfg.target_type);
    q_item.is_end_type = (s_tdata == ftsl_pkg::END_TYPE);
    q_item.short_len   = (s_tdata < ftsl_pkg::MIN_HEADER);
  end

endmodule
`default_nettype wire

// ----- src/ftsl_queue.sv -----
`default_nettype none
module ftsl_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            write,
  input  wire ftsl_pkg::item_t wr_item,
  output logic                 full,
  input  wire logic            pop,
  output logic                 valid,
  output ftsl_pkg::item_t      head
);

  ftsl_pkg::item_t entries [2];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  logic       do_wr;
  logic       do_rd;

  assign full  = (count == 2'd2);
  assign valid = (count != 2'd0);
  assign head  = entries[rptr];
  assign do_wr = write && !full;
  assign do_rd = pop && valid;

  always_ff @(posedge clk) begin
    if (do_wr) begin
      entries[wptr] <= wr_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (do_wr) begin
        wptr <= !wptr;
      end
      if (do_rd) begin
        rptr <= !rptr;
      end
      case ({do_wr, do_rd})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- src/ftsl_back.sv -----
`default_nettype none
module ftsl_back #(
  parameter int WALK_LIMIT = 65536
) (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire ftsl_pkg::cfg_t  cfg,
  input  wire logic            q_valid,
  input  wire ftsl_pkg::item_t q_head,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [((ftsl_pkg::STATUS_W + $clog2(WALK_LIMIT + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int OW = $clog2(WALK_LIMIT + 1);
  localparam int DW = ((ftsl_pkg::STATUS_W + OW + 7) / 8) * 8;
  localparam int PW = $clog2(2 * WALK_LIMIT + 3);
  localparam int CW = (PW > 17) ? PW : 17;

  logic [PW-1:0]        byte_position, byte_position_next;
  logic [PW-1:0]        structure_start, structure_start_next;
  logic [PW-1:0]        struct_offset, struct_offset_next;
  ftsl_pkg::phase_t     parse_phase, parse_phase_next;
  logic [7:0]           header_length, header_length_next;
  logic [7:0]           matches_seen, matches_seen_next;
  logic                 previous_was_zero, previous_was_zero_next;
  logic                 search_done, search_done_next;

  logic                 emit;
  ftsl_pkg::status_t    emit_status;
  logic [OW-1:0]        emit_offset;
  logic [CW-1:0]        walk_bound;
  logic [CW-1:0]        table_len_ext;

  assign q_pop = q_valid && (!m_tvalid || m_tready);

  always_comb begin
    table_len_ext = CW'(cfg.table_length);
    if (cfg.table_length == 16'd0 || table_len_ext > CW'(WALK_LIMIT)) begin
      walk_bound = CW'(WALK_LIMIT);
    end else begin
      walk_bound = table_len_ext;
    end
  end

  always_comb begin
    logic          advance;
    logic          new_struct;
    logic [PW-1:0] next_start;
    advance                = 1'b0;
    new_struct             = 1'b0;
    next_start             = byte_position + PW'(1);
    byte_position_next     = byte_position;
    structure_start_next   = structure_start;
    struct_offset_next     = struct_offset;
    parse_phase_next       = parse_phase;
    header_length_next     = header_length;
    matches_seen_next      = matches_seen;
    previous_was_zero_next = previous_was_zero;
    search_done_next       = search_done;
    emit                   = 1'b0;
    emit_status            = ftsl_pkg::ST_FOUND;
    emit_offset            = '0;

    if (q_pop) begin
      if (q_head.first_byte) begin
        byte_position_next     = '0;
        structure_start_next   = '0;
        struct_offset_next     = '0;
        parse_phase_next       = ftsl_pkg::PH_TYPE;
        header_length_next     = 8'd0;
        matches_seen_next      = 8'd0;
        previous_was_zero_next = 1'b0;
        search_done_next       = 1'b0;
        next_start             = PW'(1);
      end
      if (!search_done_next) begin
        advance = 1'b1;
        case (parse_phase_next)
          ftsl_pkg::PH_TYPE: begin
            if (q_head.is_target && matches_seen_next == cfg.target_index) begin
              emit        = 1'b1;
              emit_status = ftsl_pkg::ST_FOUND;
              emit_offset = structure_start_next[OW-1:0];
            end else if (q_head.is_end_type) begin
              emit        = 1'b1;
              emit_status = ftsl_pkg::ST_END_TYPE;
            end else begin
              if (q_head.is_target && matches_seen_next != ftsl_pkg::SEEN_MAX) begin
                matches_seen_next = matches_seen_next + 8'd1;
              end
              parse_phase_next = ftsl_pkg::PH_LENGTH;
            end
          end
          ftsl_pkg::PH_LENGTH: begin
            if (q_head.short_len) begin
              emit        = 1'b1;
              emit_status = ftsl_pkg::ST_BAD_LEN;
            end else begin
              header_length_next = q_head.data_byte;
              parse_phase_next   = ftsl_pkg::PH_BODY;
            end
          end
          ftsl_pkg::PH_BODY: begin
            if (struct_offset_next == PW'(header_length_next)) begin
              previous_was_zero_next = q_head.is_zero;
            end else if (struct_offset_next > PW'(header_length_next)) begin
              if (previous_was_zero_next && q_head.is_zero) begin
                if (CW'(next_start) > walk_bound) begin
                  emit        = 1'b1;
                  emit_status = ftsl_pkg::ST_OVER;
                end else begin
                  structure_start_next   = next_start;
                  parse_phase_next       = ftsl_pkg::PH_TYPE;
                  previous_was_zero_next = 1'b0;
                  new_struct             = 1'b1;
                end
              end else if (struct_offset_next > PW'(WALK_LIMIT)) begin
                emit        = 1'b1;
                emit_status = ftsl_pkg::ST_UNTERM;
              end else begin
                previous_was_zero_next = q_head.is_zero;
              end
            end
          end
          default: begin
            parse_phase_next = ftsl_pkg::PH_TYPE;
          end
        endcase
        if (advance && !emit) begin
          byte_position_next = next_start;
          struct_offset_next = new_struct ? '0 : struct_offset_next + PW'(1);
          if (q_head.last_byte) begin
            emit        = 1'b1;
            emit_status = ftsl_pkg::ST_STREAM;
          end
        end
        if (emit) begin
          search_done_next = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position     <= '0;
      structure_start   <= '0;
      struct_offset     <= '0;
      parse_phase       <= ftsl_pkg::PH_TYPE;
      header_length     <= 8'd0;
      matches_seen      <= 8'd0;
      previous_was_zero <= 1'b0;
      search_done       <= 1'b1;
      m_tvalid          <= 1'b0;
    end else begin
      byte_position     <= byte_position_next;
      structure_start   <= structure_start_next;
      struct_offset     <= struct_offset_next;
      parse_phase       <= parse_phase_next;
      header_length     <= header_length_next;
      matches_seen      <= matches_seen_next;
      previous_was_zero <= previous_was_zero_next;
      search_done       <= search_done_next;
      if (emit) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      m_tdata <= DW'({emit_offset, emit_status});
    end
  end

endmodule
`default_nettype wire

// ----- src/firmware_table_structure_locator_unit.sv -----
`default_nettype none
// Walks a firmware structure table streamed in one byte per transfer (tuser marks
// the byte at offset zero, tlast the final byte available) and returns one result
// per search: the offset of the target_index-th structure of type target_type, or
// the reason the walk stopped (end type, header length below 4, unterminated string
// area, next structure beyond the table length, or stream ended undecided). The
// block takes one byte every cycle: a classifying front stage writes into a
// two-entry queue and the parser drains one entry per cycle into an output
// register, so a byte is never held back unless that result register is stalled.
// A result is registered once the byte deciding it leaves the queue. Bytes after a
// decision are dropped until the next first byte. Registers are written through
// the cfg channel, which is always ready, and should change only while idle.
module firmware_table_structure_locator_unit #(
  parameter int WALK_LIMIT = 65536
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] data_byte
  input  wire logic [0:0]  s_tuser,   // [0] first_byte
  input  wire logic        s_tlast,   // last_byte
  output logic             m_tvalid,
  input  wire logic        m_tready,
  // [2:0] status, then structure_offset, zero filled to whole bytes
  output logic [((ftsl_pkg::STATUS_W + $clog2(WALK_LIMIT + 1) + 7) / 8) * 8 - 1:0] m_tdata,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [ftsl_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [ftsl_pkg::CFG_DATA_W-1:0]  cfg_data
);

  ftsl_pkg::cfg_t  cfg;
  ftsl_pkg::item_t wr_item;
  ftsl_pkg::item_t head;
  logic            q_full;
  logic            q_write;
  logic            q_valid;
  logic            q_pop;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ftsl_pkg::CFG_TARGET_TYPE:  cfg.target_type  <= cfg_data[7:0];
        ftsl_pkg::CFG_TARGET_INDEX: cfg.target_index <= cfg_data[7:0];
        ftsl_pkg::CFG_TABLE_LENGTH: cfg.table_length <= cfg_data;
        default: cfg <= cfg;
      endcase
    end
  end

  ftsl_front u_front (
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_write  (q_write),
    .q_item   (wr_item)
  );

  ftsl_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .write   (q_write),
    .wr_item (wr_item),
    .full    (q_full),
    .pop     (q_pop),
    .valid   (q_valid),
    .head    (head)
  );

  ftsl_back #(
    .WALK_LIMIT (WALK_LIMIT)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_head   (head),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule
`default_nettype wire

// ----- src/ftsl_checker.sv -----
`default_nettype none
`include "firmware_table_structure_locator_unit_macros.svh"
module ftsl_checker #(
  parameter int WALK_LIMIT = 65536
) (
  input wire logic clk,
  input wire logic rst,
  input wire logic m_tvalid,
  input wire logic m_tready,
  input wire logic [((ftsl_pkg::STATUS_W + $clog2(WALK_LIMIT + 1) + 7) / 8) * 8 - 1:0] m_tdata
);

  localparam int OW = $clog2(WALK_LIMIT + 1);
  localparam int SW = ftsl_pkg::STATUS_W;

  logic [SW-1:0] status;
  logic [OW-1:0] offset;

  assign status = m_tdata[SW-1:0];
  assign offset = m_tdata[SW+OW-1:SW];

  `FTSL_ASSERT_NEXT(a_out_hold, clk, rst, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))
  `FTSL_ASSERT_NOW(a_status_range, clk, rst, m_tvalid, status <= ftsl_pkg::ST_STREAM)
  `FTSL_ASSERT_NOW(a_offset_zero, clk, rst, m_tvalid && status != ftsl_pkg::ST_FOUND, offset == '0)
  `FTSL_ASSERT_NOW(a_offset_bound, clk, rst, m_tvalid, offset <= OW'(WALK_LIMIT))
  `FTSL_ASSERT_ALWAYS_NEXT(a_reset_quiet, clk, rst, !m_tvalid)

endmodule

bind firmware_table_structure_locator_unit ftsl_checker #(
  .WALK_LIMIT (WALK_LIMIT)
) u_ftsl_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
`default_nettype wire
